// File: hdl/i2r_pkg.sv
`default_nettype none

package i2r_pkg;

	typedef logic [11:0] value_t;
	typedef logic [6:0]  sym_t;
	typedef logic [9:0]  amount_t;

	localparam value_t MAX_VALUE = 12'd3999;

	localparam sym_t SYM_NONE = 7'h00;
	localparam sym_t SYM_M    = 7'h4D;
	localparam sym_t SYM_D    = 7'h44;
	localparam sym_t SYM_C    = 7'h43;
	localparam sym_t SYM_L    = 7'h4C;
	localparam sym_t SYM_X    = 7'h58;
	localparam sym_t SYM_V    = 7'h56;
	localparam sym_t SYM_I    = 7'h49;

	// one step of the greedy numeral table
	typedef struct packed {
		amount_t amount;
		logic    pair;
		sym_t    first;
		sym_t    second;
	} roman_ent_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic emit;
		logic half;
	} i2r_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pair;
		logic last;
	} i2r_status_t;

	// largest table step that still fits in the remainder
	function automatic roman_ent_t roman_pick(input value_t r);
		roman_ent_t e;
		if (r >= 12'd1000)     e = '{10'd1000, 1'b0, SYM_M, SYM_NONE};
		else if (r >= 12'd900) e = '{10'd900,  1'b1, SYM_C, SYM_M};
		else if (r >= 12'd500) e = '{10'd500,  1'b0, SYM_D, SYM_NONE};
		else if (r >= 12'd400) e = '{10'd400,  1'b1, SYM_C, SYM_D};
		else if (r >= 12'd100) e = '{10'd100,  1'b0, SYM_C, SYM_NONE};
		else if (r >= 12'd90)  e = '{10'd90,   1'b1, SYM_X, SYM_C};
		else if (r >= 12'd50)  e = '{10'd50,   1'b0, SYM_L, SYM_NONE};
		else if (r >= 12'd40)  e = '{10'd40,   1'b1, SYM_X, SYM_L};
		else if (r >= 12'd10)  e = '{10'd10,   1'b0, SYM_X, SYM_NONE};
		else if (r >= 12'd9)   e = '{10'd9,    1'b1, SYM_I, SYM_X};
		else if (r >= 12'd5)   e = '{10'd5,    1'b0, SYM_V, SYM_NONE};
		else if (r >= 12'd4)   e = '{10'd4,    1'b1, SYM_I, SYM_V};
		else                   e = '{10'd1,    1'b0, SYM_I, SYM_NONE};
		return e;
	endfunction

endpackage

`default_nettype wire

// File: hdl/i2r_value_if.sv
`default_nettype none

interface i2r_value_if;
	logic                valid;
	logic                ready;
	i2r_pkg::value_t     value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// File: hdl/i2r_result_if.sv
`default_nettype none

interface i2r_result_if;
	logic                valid;
	logic                ready;
	i2r_pkg::sym_t       symbol;
	logic                last;
	logic                error;

	modport source (output valid, output symbol, output last, output error, input ready);
	modport sink   (input valid, input symbol, input last, input error, output ready);
endinterface

`default_nettype wire

// File: hdl/i2r_ctrl.sv
`default_nettype none

module i2r_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire i2r_pkg::i2r_status_t status,
	output i2r_pkg::i2r_cmd_t         cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;
	logic   half_q;
	logic   out_valid_q;
	logic   emit;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	// output register free or being drained this cycle
	assign emit      = (state_q == ST_RUN) && (!out_valid_q || out_ready);

	assign cmd.load = in_valid && in_ready;
	assign cmd.emit = emit;
	assign cmd.half = half_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			half_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					half_q <= 1'b0;
					if (in_valid) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (emit) begin
						half_q <= status.pair && !half_q;
						if (status.last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hdl/i2r_dp.sv
`default_nettype none

module i2r_dp (
	input  wire logic               clk,
	input  wire i2r_pkg::value_t    value,
	input  wire i2r_pkg::i2r_cmd_t  cmd,
	output i2r_pkg::i2r_status_t    status,
	output i2r_pkg::sym_t           symbol,
	output logic                    last,
	output logic                    error
);

	i2r_pkg::value_t     rem_q;
	logic                err_q;
	i2r_pkg::sym_t       symbol_q;
	logic                last_q;
	logic                error_q;
	i2r_pkg::roman_ent_t ent;
	i2r_pkg::value_t     rem_next;
	logic                take;
	i2r_pkg::sym_t       sym_sel;

	assign ent      = i2r_pkg::roman_pick(rem_q);
	assign rem_next = rem_q - {2'b00, ent.amount};
	// remainder drops on a single letter or on the second letter of a pair
	assign take     = !ent.pair || cmd.half;
	assign sym_sel  = cmd.half ? ent.second : ent.first;

	assign status.pair = ent.pair && !err_q;
	assign status.last = err_q || (take && (rem_next == '0));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= value;
			err_q <= (value == '0) || (value > i2r_pkg::MAX_VALUE);
		end else if (cmd.emit && take) begin
			rem_q <= rem_next;
		end
		if (cmd.emit) begin
			symbol_q <= err_q ? i2r_pkg::SYM_NONE : sym_sel;
			last_q   <= status.last;
			error_q  <= err_q;
		end
	end

	assign symbol = symbol_q;
	assign last   = last_q;
	assign error  = error_q;

endmodule

`default_nettype wire

// File: hdl/integer_to_roman_numeral_core.sv
// channel    | dir | payload                     | handshake
// value_ch   | in  | value[11:0]                 | valid/ready
// result_ch  | out | symbol[6:0], last, error    | valid/ready
//
// an item is loaded, then emitted as 1 to 15 characters, 1 for an out-of-range
// value; the greedy step unit gives one letter a cycle while result_ch is not
// stalled; the next value is taken the cycle after the final character enters
// the output register, even while that character still waits on result_ch.ready
// arst_n clears the controller; a stalled output holds the whole run
`default_nettype none

module integer_to_roman_numeral_core (
	input  wire logic    clk,
	input  wire logic    arst_n,
	i2r_value_if.sink    value_ch,
	i2r_result_if.source result_ch
);

	i2r_pkg::i2r_cmd_t    cmd;
	i2r_pkg::i2r_status_t status;

	i2r_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (value_ch.valid),
		.in_ready  (value_ch.ready),
		.out_valid (result_ch.valid),
		.out_ready (result_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	i2r_dp u_dp (
		.clk    (clk),
		.value  (value_ch.value),
		.cmd    (cmd),
		.status (status),
		.symbol (result_ch.symbol),
		.last   (result_ch.last),
		.error  (result_ch.error)
	);

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	typedef struct packed {
		i2r_pkg::sym_t symbol;
		logic          last;
		logic          error;
	} numeral_char_t;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_EVERY_THIRD,
		READY_HALF,
		READY_MOSTLY
	} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	i2r_value_if  value_ch ();
	i2r_result_if result_ch ();

	integer_to_roman_numeral_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.value_ch  (value_ch),
		.result_ch (result_ch)
	);

	i2r_pkg::value_t pending_values[$];
	numeral_char_t   expected_chars[$];
	numeral_char_t   want_char;
	int              total_values;
	int              taken_count = 0;
	int              mismatch_count = 0;
	int              burst_left = 0;
	int              gap_left = 0;
	int              phase_count = 0;
	int              hold_cycles = 0;
	stall_mode_t     stall_mode = READY_ALWAYS;
	logic            hold_off = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// expected character run for one value
	function automatic void predict_numeral(input i2r_pkg::value_t v);
		i2r_pkg::sym_t letters[$];
		i2r_pkg::sym_t ones_l[3] = '{i2r_pkg::SYM_C, i2r_pkg::SYM_X, i2r_pkg::SYM_I};
		i2r_pkg::sym_t five_l[3] = '{i2r_pkg::SYM_D, i2r_pkg::SYM_L, i2r_pkg::SYM_V};
		i2r_pkg::sym_t ten_l[3]  = '{i2r_pkg::SYM_M, i2r_pkg::SYM_C, i2r_pkg::SYM_X};
		int unsigned   scale[3]  = '{100, 10, 1};
		int unsigned   n;
		int unsigned   d;
		if (v == 0 || v > i2r_pkg::MAX_VALUE) begin
			expected_chars.push_back('{i2r_pkg::SYM_NONE, 1'b1, 1'b1});
			return;
		end
		n = v;
		repeat (n / 1000) letters.push_back(i2r_pkg::SYM_M);
		for (int p = 0; p < 3; p++) begin
			d = (n / scale[p]) % 10;
			if (d == 9) begin
				letters.push_back(ones_l[p]);
				letters.push_back(ten_l[p]);
			end else if (d == 4) begin
				letters.push_back(ones_l[p]);
				letters.push_back(five_l[p]);
			end else begin
				if (d >= 5) begin
					letters.push_back(five_l[p]);
					d -= 5;
				end
				repeat (d) letters.push_back(ones_l[p]);
			end
		end
		foreach (letters[i])
			expected_chars.push_back('{letters[i], (i == letters.size() - 1), 1'b0});
	endfunction

	// sender: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_ch.valid <= 1'b0;
			value_ch.value <= '0;
		end else begin
			if (value_ch.valid && value_ch.ready) begin
				predict_numeral(value_ch.value);
				taken_count++;
			end
			if (!value_ch.valid || value_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					value_ch.valid <= 1'b0;
				end else if (pending_values.size() > 0) begin
					value_ch.valid <= 1'b1;
					value_ch.value <= pending_values.pop_front();
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						case ($urandom_range(3))
							0: gap_left = 0;
							1: gap_left = $urandom_range(1, 3);
							2: gap_left = $urandom_range(4, 12);
							default: gap_left = $urandom_range(13, 40);
						endcase
					end
				end else begin
					value_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off so the core backs up and stalls its input
	always @(posedge clk) begin
		if (arst_n) begin
			hold_cycles++;
			hold_off <= (hold_cycles >= 300 && hold_cycles < 700) ||
				(hold_cycles >= 2500 && hold_cycles < 2800);
		end
	end

	// receiver: check each transaction, stall on a changing pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_chars.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected result: expected none, %s %h last %b error %b",
						$time, "actual symbol", result_ch.symbol, result_ch.last,
						result_ch.error);
				end else begin
					want_char = expected_chars.pop_front();
					if (result_ch.symbol !== want_char.symbol) begin
						mismatch_count++;
						$display("%0t: symbol mismatch: expected %h actual %h",
							$time, want_char.symbol, result_ch.symbol);
					end
					if (result_ch.last !== want_char.last) begin
						mismatch_count++;
						$display("%0t: last mismatch: expected %b actual %b",
							$time, want_char.last, result_ch.last);
					end
					if (result_ch.error !== want_char.error) begin
						mismatch_count++;
						$display("%0t: error mismatch: expected %b actual %b",
							$time, want_char.error, result_ch.error);
					end
				end
			end
			phase_count++;
			if (phase_count % 64 == 0)
				stall_mode = stall_mode_t'($urandom_range(3));
			case (stall_mode)
				READY_ALWAYS:      result_ch.ready <= !hold_off;
				READY_EVERY_THIRD: result_ch.ready <= !hold_off && (phase_count % 3 == 0);
				READY_HALF:        result_ch.ready <= !hold_off && ($urandom_range(1) == 1);
				default:           result_ch.ready <= !hold_off && ($urandom_range(9) != 0);
			endcase
		end
	end

	initial begin
		// extremes, out-of-range values and each subtractive pair
		pending_values = '{12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888,
			12'd4, 12'd9, 12'd40, 12'd90, 12'd400, 12'd900, 12'd5, 12'd8,
			12'd1000, 12'd2048, 12'd1994, 12'd444, 12'd999, 12'd3, 12'd2730,
			12'd1365, 12'd3000, 12'd4001};
		repeat (400) begin
			case ($urandom_range(19))
				0: pending_values.push_back(i2r_pkg::value_t'($urandom_range(4000, 4095)));
				1: pending_values.push_back(12'd0);
				2: pending_values.push_back(i2r_pkg::value_t'($urandom_range(1, 99)));
				default: pending_values.push_back(i2r_pkg::value_t'($urandom_range(1, 3999)));
			endcase
		end
		total_values = pending_values.size();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (taken_count < total_values) @(posedge clk);
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#1ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
